>>> design/vrps_pkg.sv
// Shared types and constants of the video register port scroll unit.
`timescale 1ns / 1ps

package vrps_pkg;

    localparam int TABLE_BYTES  = 1024;
    localparam int SPRITE_BYTES = 256;
    localparam int PAL_BYTES    = 32;
    localparam int NAME_BYTES   = 2 * TABLE_BYTES;
    localparam int NAME_AW      = $clog2(NAME_BYTES);
    localparam int SPR_AW       = $clog2(SPRITE_BYTES);
    localparam int PAL_AW       = $clog2(PAL_BYTES);

    typedef enum logic [2:0] {
        KIND_READ     = 3'd0,
        KIND_WRITE    = 3'd1,
        KIND_VBLANK   = 3'd2,
        KIND_PRERENDER = 3'd3,
        KIND_INC_X    = 3'd4,
        KIND_INC_Y    = 3'd5,
        KIND_COPY_X   = 3'd6,
        KIND_COPY_Y   = 3'd7
    } kind_t;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_OAMADR = 3'd3;
    localparam logic [2:0] REG_OAMDAT = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    localparam logic [13:0] PAT_END   = 14'h2000;
    localparam logic [13:0] PAL_START = 14'h3F00;
    localparam logic [15:0] COPY_X_MASK = 16'h041F;
    localparam logic [15:0] COPY_Y_MASK = 16'h7BE0;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic               rd_en;
        logic               name_we;
        logic               pal_we;
        logic               spr_we;
        logic [NAME_AW-1:0] name_addr;
        logic [PAL_AW-1:0]  pal_addr;
        logic [SPR_AW-1:0]  spr_addr;
        logic [7:0]         wdata;
    } mem_req_t;

endpackage

>>> design/vrps_mem.sv
// Nametable, palette and sprite byte memories with the clearing pass after reset.
`timescale 1ns / 1ps

module vrps_mem
(
    input  logic              clk,
    input  logic              rst_n,
    input  vrps_pkg::mem_req_t req,
    output logic [7:0]        name_q,
    output logic [7:0]        pal_q,
    output logic [7:0]        spr_q,
    output logic              busy
);
    import vrps_pkg::*;

    logic [7:0] name_mem [NAME_BYTES];
    logic [7:0] pal_mem [PAL_BYTES];
    logic [7:0] spr_mem [SPRITE_BYTES];

    logic               clear_busy_reg;
    logic [NAME_AW-1:0] clear_cnt_reg;

    assign busy = clear_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_cnt_reg  <= '0;
        end
        else if (clear_busy_reg)
        begin
            clear_cnt_reg <= clear_cnt_reg + NAME_AW'(1);
            if (clear_cnt_reg == {NAME_AW{1'b1}})
            begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_busy_reg)
        begin
            name_mem[clear_cnt_reg] <= 8'h00;
        end
        else if (req.name_we)
        begin
            name_mem[req.name_addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            name_q <= name_mem[req.name_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_busy_reg)
        begin
            pal_mem[clear_cnt_reg[PAL_AW-1:0]] <= 8'h00;
        end
        else if (req.pal_we)
        begin
            pal_mem[req.pal_addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            pal_q <= pal_mem[req.pal_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_busy_reg)
        begin
            spr_mem[clear_cnt_reg[SPR_AW-1:0]] <= 8'h00;
        end
        else if (req.spr_we)
        begin
            spr_mem[req.spr_addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            spr_q <= spr_mem[req.spr_addr];
        end
    end

endmodule

>>> design/video_register_port_scroll_unit.sv
// Top level of the video register port scroll unit.
`timescale 1ns / 1ps
// The slave stream carries one item per transfer: CPU register reads and
// writes and the timing events of the picture unit, with the event kind in
// s_tuser. Every item gives exactly one result on the master stream: the
// read byte, the interrupt flag, the VRAM address and the fine x scroll.
// The single bit on the cfg channel selects nametable mirroring; the user
// must write it only while no item is in flight, which the block itself
// does not enforce, and cfg_ready is always high. An item is taken when the
// memories are read at the current VRAM address and sprite pointer. Then,
// in ST_EXEC, once the output register is empty or being transferred, the
// registers and the memories are updated and the result enters the output
// register. One item is worked on at a time: a new item is not taken until
// the last one has left ST_EXEC. After reset the nametable, palette and
// sprite memories are cleared, during which s_tready stays low.
// When the receiver stalls, the result waits in the output register and the
// next item is still taken; its update then waits until that result has
// been transferred.

module video_register_port_scroll_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // reg_index[2:0], write_data[10:3], zero fill
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data[7:0], nmi_raise[8], vram_address[24:9],
                                   // fine_x_scroll[27:25], zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import vrps_pkg::*;

    state_t      state_reg, state_next;
    logic        mirror_mode_reg;
    logic [7:0]  control_reg, control_next;
    logic [7:0]  mask_reg, mask_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  spr_ptr_reg, spr_ptr_next;
    logic [15:0] cur_addr_reg, cur_addr_next;
    logic [15:0] temp_addr_reg, temp_addr_next;
    logic [2:0]  fine_x_reg, fine_x_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  read_buf_reg, read_buf_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;

    kind_t       kind_reg;
    logic [2:0]  reg_index_reg;
    logic [7:0]  write_data_reg;

    mem_req_t    req;
    logic [7:0]  name_q, pal_q, spr_q;
    logic        mem_busy;

    logic        accept;
    logic        go;
    logic [13:0] bus_addr;
    logic        is_pat, is_pal;
    logic [11:0] name_off;
    logic        name_bank;
    logic [4:0]  pal_index;
    logic        rendering;
    logic [15:0] advanced_addr;
    logic [7:0]  rd_byte;
    logic        nmi;
    logic [4:0]  tile_row;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && !mem_busy;
    assign accept    = s_tvalid && s_tready;
    assign go        = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign bus_addr  = cur_addr_reg[13:0];
    assign is_pat    = bus_addr < PAT_END;
    assign is_pal    = bus_addr >= PAL_START;
    assign name_off  = cur_addr_reg[11:0];
    assign name_bank = mirror_mode_reg ? name_off[11] : name_off[10];
    assign rendering = (mask_reg[4:3] != 2'b00);
    assign advanced_addr = cur_addr_reg + (control_reg[2] ? 16'd32 : 16'd1);

    always_comb
    begin
        pal_index = cur_addr_reg[4:0];
        if (pal_index[4] && (pal_index[1:0] == 2'b00))
        begin
            pal_index[4] = 1'b0;
        end
    end

    always_comb
    begin
        req.rd_en     = accept;
        req.name_we   = 1'b0;
        req.pal_we    = 1'b0;
        req.spr_we    = 1'b0;
        req.name_addr = {name_bank, name_off[9:0]};
        req.pal_addr  = pal_index;
        req.spr_addr  = spr_ptr_reg;
        req.wdata     = write_data_reg;
        if (go && (kind_reg == KIND_WRITE))
        begin
            if (reg_index_reg == REG_OAMDAT)
            begin
                req.spr_we = 1'b1;
            end
            if ((reg_index_reg == REG_DATA) && !is_pat)
            begin
                req.name_we = !is_pal;
                req.pal_we  = is_pal;
            end
        end
    end

    vrps_mem u_mem
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .name_q (name_q),
        .pal_q  (pal_q),
        .spr_q  (spr_q),
        .busy   (mem_busy)
    );

    always_comb
    begin
        state_next     = state_reg;
        control_next   = control_reg;
        mask_next      = mask_reg;
        status_next    = status_reg;
        spr_ptr_next   = spr_ptr_reg;
        cur_addr_next  = cur_addr_reg;
        temp_addr_next = temp_addr_reg;
        fine_x_next    = fine_x_reg;
        toggle_next    = toggle_reg;
        read_buf_next  = read_buf_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rd_byte        = 8'h00;
        nmi            = 1'b0;
        tile_row       = cur_addr_reg[9:5];

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (go)
                begin
                    state_next = ST_IDLE;
                    case (kind_reg)
                        KIND_READ:
                        begin
                            case (reg_index_reg)
                                REG_STATUS:
                                begin
                                    rd_byte = {status_reg[7:5], read_buf_reg[4:0]};
                                    status_next[7] = 1'b0;
                                    toggle_next = 1'b0;
                                end
                                REG_OAMDAT:
                                begin
                                    rd_byte = spr_q;
                                end
                                REG_DATA:
                                begin
                                    if (is_pal)
                                    begin
                                        rd_byte = pal_q;
                                        read_buf_next = name_q;
                                    end
                                    else
                                    begin
                                        rd_byte = read_buf_reg;
                                        read_buf_next = is_pat ? 8'h00 : name_q;
                                    end
                                    cur_addr_next = advanced_addr;
                                end
                                default:
                                begin
                                    rd_byte = 8'h00;
                                end
                            endcase
                        end
                        KIND_WRITE:
                        begin
                            case (reg_index_reg)
                                REG_CTRL:
                                begin
                                    control_next = write_data_reg;
                                    temp_addr_next[11:10] = write_data_reg[1:0];
                                    nmi = write_data_reg[7] && status_reg[7];
                                end
                                REG_MASK:
                                begin
                                    mask_next = write_data_reg;
                                end
                                REG_OAMADR:
                                begin
                                    spr_ptr_next = write_data_reg;
                                end
                                REG_OAMDAT:
                                begin
                                    spr_ptr_next = spr_ptr_reg + 8'd1;
                                end
                                REG_SCROLL:
                                begin
                                    if (!toggle_reg)
                                    begin
                                        fine_x_next = write_data_reg[2:0];
                                        temp_addr_next[4:0] = write_data_reg[7:3];
                                        toggle_next = 1'b1;
                                    end
                                    else
                                    begin
                                        temp_addr_next[14:12] = write_data_reg[2:0];
                                        temp_addr_next[9:5] = write_data_reg[7:3];
                                        toggle_next = 1'b0;
                                    end
                                end
                                REG_ADDR:
                                begin
                                    if (!toggle_reg)
                                    begin
                                        temp_addr_next = {2'b00, write_data_reg[5:0],
                                                          temp_addr_reg[7:0]};
                                        toggle_next = 1'b1;
                                    end
                                    else
                                    begin
                                        temp_addr_next = {temp_addr_reg[15:8], write_data_reg};
                                        cur_addr_next = {temp_addr_reg[15:8], write_data_reg};
                                        toggle_next = 1'b0;
                                    end
                                end
                                REG_DATA:
                                begin
                                    cur_addr_next = advanced_addr;
                                end
                                default:
                                begin
                                    nmi = 1'b0;
                                end
                            endcase
                        end
                        KIND_VBLANK:
                        begin
                            status_next[7] = 1'b1;
                            nmi = control_reg[7];
                        end
                        KIND_PRERENDER:
                        begin
                            status_next[7:5] = 3'b000;
                        end
                        KIND_INC_X:
                        begin
                            if (rendering)
                            begin
                                if (cur_addr_reg[4:0] == 5'd31)
                                begin
                                    cur_addr_next[4:0] = 5'd0;
                                    cur_addr_next[10] = !cur_addr_reg[10];
                                end
                                else
                                begin
                                    cur_addr_next = cur_addr_reg + 16'd1;
                                end
                            end
                        end
                        KIND_INC_Y:
                        begin
                            if (rendering)
                            begin
                                if (cur_addr_reg[14:12] != 3'd7)
                                begin
                                    cur_addr_next[14:12] = cur_addr_reg[14:12] + 3'd1;
                                end
                                else
                                begin
                                    cur_addr_next[14:12] = 3'd0;
                                    if (cur_addr_reg[9:5] == 5'd29)
                                    begin
                                        tile_row = 5'd0;
                                        cur_addr_next[11] = !cur_addr_reg[11];
                                    end
                                    else if (cur_addr_reg[9:5] == 5'd31)
                                    begin
                                        tile_row = 5'd0;
                                    end
                                    else
                                    begin
                                        tile_row = cur_addr_reg[9:5] + 5'd1;
                                    end
                                    cur_addr_next[9:5] = tile_row;
                                end
                            end
                        end
                        KIND_COPY_X:
                        begin
                            if (rendering)
                            begin
                                cur_addr_next = (cur_addr_reg & ~COPY_X_MASK)
                                              | (temp_addr_reg & COPY_X_MASK);
                            end
                        end
                        KIND_COPY_Y:
                        begin
                            if (rendering)
                            begin
                                cur_addr_next = (cur_addr_reg & ~COPY_Y_MASK)
                                              | (temp_addr_reg & COPY_Y_MASK);
                            end
                        end
                        default:
                        begin
                            nmi = 1'b0;
                        end
                    endcase
                    out_valid_next = 1'b1;
                    out_data_next  = {4'h0, fine_x_next, cur_addr_next, nmi, rd_byte};
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mirror_mode_reg <= 1'b0;
            control_reg     <= 8'h00;
            mask_reg        <= 8'h00;
            status_reg      <= 8'h00;
            spr_ptr_reg     <= 8'h00;
            cur_addr_reg    <= 16'h0000;
            temp_addr_reg   <= 16'h0000;
            fine_x_reg      <= 3'd0;
            toggle_reg      <= 1'b0;
            read_buf_reg    <= 8'h00;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                mirror_mode_reg <= cfg_data;
            end
            control_reg   <= control_next;
            mask_reg      <= mask_next;
            status_reg    <= status_next;
            spr_ptr_reg   <= spr_ptr_next;
            cur_addr_reg  <= cur_addr_next;
            temp_addr_reg <= temp_addr_next;
            fine_x_reg    <= fine_x_next;
            toggle_reg    <= toggle_next;
            read_buf_reg  <= read_buf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept)
        begin
            kind_reg       <= kind_t'(s_tuser);
            reg_index_reg  <= s_tdata[2:0];
            write_data_reg <= s_tdata[10:3];
        end
    end

endmodule

>>> design/vrps_checker.sv
// Port checker of the video register port scroll unit and its bind.
`timescale 1ns / 1ps

module vrps_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A result that was not taken stays in place unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Only writes and vblank raise the interrupt, and they return no read byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'h00)
        else $error("interrupt result carries read data");

    // One item is worked on at a time: no transfer in the cycle after one.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in two consecutive cycles");

    // The unused upper bits of the result are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:28] == 4'h0)
        else $error("result fill bits not zero");

endmodule

bind video_register_port_scroll_unit vrps_checker u_vrps_checker (.*);
